// File: sv/assert_macros.svh
// Assertion helpers shared by the glyph layout RTL.
// Both expect clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define GQL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gql: assertion failed");

// condition must never be seen at a clock edge out of reset
`define GQL_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gql: forbidden condition seen");

`endif

// File: sv/gql_pkg.sv
package gql_pkg;

    localparam int GLYPH_SLOTS_DEF = 256;
    localparam int QUEUE_DEPTH     = 8;

    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPACING    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPACE_ADV  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_ADV   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FONT_STYLE = 3'd4;

    localparam logic [15:0] CODE_NL  = 16'd10;
    localparam logic [15:0] CODE_SP  = 16'd32;
    localparam logic [15:0] CODE_TAB = 16'd9;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LAYOUT = 1'b1;

    localparam logic KIND_VERTEX  = 1'b0;
    localparam logic KIND_MISSING = 1'b1;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd3;

    // what the back end does with one layout request
    typedef enum logic [2:0] {
        ACT_MISS    = 3'd0,
        ACT_NEWLINE = 3'd1,
        ACT_SPACE   = 3'd2,
        ACT_TAB     = 3'd3,
        ACT_GLYPH   = 3'd4
    } act_t;

    typedef struct packed {
        logic [15:0]       scale;
        logic signed [7:0] spacing;
        logic [11:0]       space_adv;
        logic [11:0]       line_adv;
        logic [5:0]        style;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic [15:0]        char_code;
        logic               first_char;
        logic [5:0]         load_style;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic [15:0]        tex_left;
        logic [15:0]        tex_right;
        logic [15:0]        tex_top;
        logic [15:0]        tex_bottom;
    } req_t;

    // classified request, metrics already scaled
    typedef struct packed {
        act_t        act;
        logic        first;
        logic [15:0] code;
        logic [15:0] sox;
        logic [15:0] soy;
        logic [15:0] sw;
        logic [15:0] sh;
        logic [15:0] sadv;
        logic [15:0] tl;
        logic [15:0] tr;
        logic [15:0] tt;
        logic [15:0] tb;
    } entry_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         corner;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [15:0]        missing_code;
        logic               last;
    } res_t;

endpackage

// File: sv/gql_front.sv
`include "assert_macros.svh"

module gql_front #(
    parameter int GLYPH_SLOTS = gql_pkg::GLYPH_SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gql_pkg::cfg_t   cfg,
    input  logic            push,
    output logic            full,
    input  gql_pkg::req_t   req,
    input  logic            deq,
    output logic            enq_valid,
    output gql_pkg::entry_t enq_entry
);

    localparam int QDEPTH  = gql_pkg::QUEUE_DEPTH;
    localparam int SLOT_W  = $clog2(GLYPH_SLOTS);
    localparam int CRED_W  = $clog2(QDEPTH + 1);
    localparam int TAG_W   = 23;
    // slot = code mod GLYPH_SLOTS via reciprocal; exact for 16-bit codes
    localparam int RECIP_W = 34 - SLOT_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << 32) / GLYPH_SLOTS + 1);

    function automatic logic [15:0] scale16(input logic signed [16:0] v,
                                            input logic [15:0] s);
        logic signed [33:0] p;
        logic signed [33:0] b;
        p = v * $signed({1'b0, s});
        b = p + (p[33] ? 34'sd255 : 34'sd0);
        scale16 = 16'(b >>> 8);
    endfunction

    logic accept;
    logic layout_in;

    // credits: layout requests in the pipe plus entries in the queue
    logic [CRED_W-1:0] cred_reg, cred_next;

    logic              clr_busy_reg, clr_busy_next;
    logic [SLOT_W-1:0] clr_idx_reg, clr_idx_next;

    logic                  s1_valid_reg;
    gql_pkg::req_t         s1_req_reg;
    logic [15+RECIP_W:0]   s1_prod;

    logic                  s2_valid_reg;
    gql_pkg::req_t         s2_req_reg;
    logic [15:0]           s2_q_reg;
    logic [15:0]           s2_qn;
    logic [15:0]           s2_rem;
    logic [SLOT_W-1:0]     slot;

    logic                  s3_valid_reg;
    logic [15:0]           s3_code_reg;
    logic                  s3_first_reg;

    logic [TAG_W-1:0] tag_mem [GLYPH_SLOTS];
    logic [63:0]      box_mem [GLYPH_SLOTS];
    logic [63:0]      tex_mem [GLYPH_SLOTS];
    logic [TAG_W-1:0] tag_rd_reg;
    logic [63:0]      box_rd_reg;
    logic [63:0]      tex_rd_reg;

    logic              tag_we;
    logic [SLOT_W-1:0] tag_waddr;
    logic [TAG_W-1:0]  tag_wdata;
    logic              load_we;

    logic              hit;
    logic signed [16:0] w_ext;
    logic signed [16:0] adv_ext;

    assign full      = clr_busy_reg || (cred_reg == CRED_W'(QDEPTH));
    assign accept    = push && !full;
    assign layout_in = accept && (req.req_type == gql_pkg::REQ_LAYOUT);

    always_comb
    begin
        cred_next = cred_reg;
        case ({layout_in, deq})
            2'b10:   cred_next = cred_reg + 1'b1;
            2'b01:   cred_next = cred_reg - 1'b1;
            default: cred_next = cred_reg;
        endcase
    end

    // tag clearing sweep after reset
    always_comb
    begin
        clr_idx_next  = clr_idx_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == SLOT_W'(GLYPH_SLOTS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cred_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            cred_reg     <= cred_next;
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && (s2_req_reg.req_type == gql_pkg::REQ_LAYOUT);
        end
    end

    // stage 1: reciprocal product for the slot index
    assign s1_prod = s1_req_reg.char_code * RECIP;

    // stage 2: remainder, table access
    assign s2_qn  = 16'(32'(s2_q_reg) * 32'(GLYPH_SLOTS));
    assign s2_rem = s2_req_reg.char_code - s2_qn;
    assign slot   = s2_rem[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
        s2_req_reg   <= s1_req_reg;
        s2_q_reg     <= 16'(s1_prod >> 32);
        s3_code_reg  <= s2_req_reg.char_code;
        s3_first_reg <= s2_req_reg.first_char;
    end

    assign load_we   = s2_valid_reg && (s2_req_reg.req_type == gql_pkg::REQ_LOAD);
    assign tag_we    = clr_busy_reg || load_we;
    assign tag_waddr = clr_busy_reg ? clr_idx_reg : slot;
    assign tag_wdata = clr_busy_reg ? '0
                     : {1'b1, s2_req_reg.load_style, s2_req_reg.char_code};

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rd_reg <= tag_mem[slot];
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            box_mem[slot] <= {s2_req_reg.box_height, s2_req_reg.box_width,
                              s2_req_reg.offset_y, s2_req_reg.offset_x};
            tex_mem[slot] <= {s2_req_reg.tex_bottom, s2_req_reg.tex_top,
                              s2_req_reg.tex_right, s2_req_reg.tex_left};
        end
        box_rd_reg <= box_mem[slot];
        tex_rd_reg <= tex_mem[slot];
    end

    // stage 3: classify and scale
    assign hit     = (tag_rd_reg == {1'b1, cfg.style, s3_code_reg});
    assign w_ext   = {box_rd_reg[47], box_rd_reg[47:32]};
    assign adv_ext = w_ext + {{9{cfg.spacing[7]}}, cfg.spacing};

    always_comb
    begin
        enq_entry.act = gql_pkg::ACT_GLYPH;
        if (!hit)
        begin
            enq_entry.act = gql_pkg::ACT_MISS;
        end
        else
        begin
            unique case (s3_code_reg)
                gql_pkg::CODE_NL:  enq_entry.act = gql_pkg::ACT_NEWLINE;
                gql_pkg::CODE_SP:  enq_entry.act = gql_pkg::ACT_SPACE;
                gql_pkg::CODE_TAB: enq_entry.act = gql_pkg::ACT_TAB;
                default:           enq_entry.act = gql_pkg::ACT_GLYPH;
            endcase
        end
        enq_entry.first = s3_first_reg;
        enq_entry.code  = s3_code_reg;
        enq_entry.sox   = scale16({box_rd_reg[15], box_rd_reg[15:0]}, cfg.scale);
        enq_entry.soy   = scale16({box_rd_reg[31], box_rd_reg[31:16]}, cfg.scale);
        enq_entry.sw    = scale16(w_ext, cfg.scale);
        enq_entry.sh    = scale16({box_rd_reg[63], box_rd_reg[63:48]}, cfg.scale);
        enq_entry.sadv  = scale16(adv_ext, cfg.scale);
        enq_entry.tl    = tex_rd_reg[15:0];
        enq_entry.tr    = tex_rd_reg[31:16];
        enq_entry.tt    = tex_rd_reg[47:32];
        enq_entry.tb    = tex_rd_reg[63:48];
    end

    assign enq_valid = s3_valid_reg;

    `GQL_NEVER(a_cred_bound, cred_reg > CRED_W'(QDEPTH))
    `GQL_NEVER(a_no_enq_in_clear, clr_busy_reg && (s1_valid_reg || enq_valid))

endmodule

// File: sv/gql_fifo.sv
`include "assert_macros.svh"

module gql_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gql_pkg::entry_t din,
    input  logic            pop,
    output gql_pkg::entry_t dout,
    output logic            nonempty
);

    localparam int DEPTH = gql_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gql_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout     = mem_reg[rd_ptr_reg];
    assign nonempty = (cnt_reg != '0);

    `GQL_NEVER(a_no_overflow, push && !pop && (cnt_reg == CNT_W'(DEPTH)))
    `GQL_NEVER(a_no_underflow, pop && (cnt_reg == '0))

endmodule

// File: sv/gql_back.sv
`include "assert_macros.svh"

module gql_back (
    input  logic            clk,
    input  logic            rst_n,
    input  gql_pkg::cfg_t   cfg,
    input  logic            head_valid,
    input  gql_pkg::entry_t head,
    output logic            deq,
    output logic            empty,
    input  logic            pop,
    output gql_pkg::res_t   res
);

    logic            cur_valid_reg, cur_valid_next;
    gql_pkg::entry_t cur_reg;
    logic [1:0]      corner_reg, corner_next;
    logic [15:0]     pen_x_reg, pen_x_next;
    logic [15:0]     pen_line_reg, pen_line_next;
    logic            out_valid_reg, out_valid_next;
    gql_pkg::res_t   out_reg, out_next;

    logic        out_free;
    logic        emit;
    logic        done;
    logic        take;
    logic [15:0] left, right, top, bottom;

    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        emit = 1'b0;
        done = 1'b0;
        if (cur_valid_reg)
        begin
            case (cur_reg.act) inside
                gql_pkg::ACT_NEWLINE, gql_pkg::ACT_SPACE, gql_pkg::ACT_TAB:
                begin
                    done = 1'b1;
                end
                gql_pkg::ACT_MISS:
                begin
                    emit = out_free;
                    done = out_free;
                end
                gql_pkg::ACT_GLYPH:
                begin
                    emit = out_free;
                    done = out_free && (corner_reg == gql_pkg::CORNER_BR);
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    assign take = head_valid && (!cur_valid_reg || done);
    assign deq  = take;

    // quad edges from the current pen
    assign left   = pen_x_reg + cur_reg.sox;
    assign right  = left + cur_reg.sw;
    assign top    = pen_line_reg + cur_reg.soy;
    assign bottom = top + cur_reg.sh;

    always_comb
    begin
        pen_x_next    = pen_x_reg;
        pen_line_next = pen_line_reg;
        if (done)
        begin
            case (cur_reg.act)
                gql_pkg::ACT_NEWLINE:
                begin
                    pen_line_next = pen_line_reg + {4'b0, cfg.line_adv};
                    pen_x_next    = '0;
                end
                gql_pkg::ACT_SPACE: pen_x_next = pen_x_reg + {4'b0, cfg.space_adv};
                gql_pkg::ACT_TAB:   pen_x_next = pen_x_reg + {2'b0, cfg.space_adv, 2'b0};
                gql_pkg::ACT_GLYPH: pen_x_next = pen_x_reg + cur_reg.sadv;
                default:            pen_x_next = pen_x_reg;
            endcase
        end
        // first character of a string restarts the layout
        if (take && head.first)
        begin
            pen_x_next    = '0;
            pen_line_next = '0;
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        corner_next    = corner_reg;
        if (take)
        begin
            cur_valid_next = 1'b1;
            corner_next    = gql_pkg::CORNER_TL;
        end
        else
        begin
            if (done)
            begin
                cur_valid_next = 1'b0;
            end
            if (emit && (cur_reg.act == gql_pkg::ACT_GLYPH))
            begin
                corner_next = corner_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (cur_reg.act == gql_pkg::ACT_MISS)
            begin
                out_next.kind         = gql_pkg::KIND_MISSING;
                out_next.corner       = gql_pkg::CORNER_TL;
                out_next.x            = '0;
                out_next.y            = '0;
                out_next.u            = '0;
                out_next.v            = '0;
                out_next.missing_code = cur_reg.code;
                out_next.last         = 1'b1;
            end
            else
            begin
                out_next.kind         = gql_pkg::KIND_VERTEX;
                out_next.corner       = corner_reg;
                out_next.x            = corner_reg[0] ? right : left;
                out_next.y            = corner_reg[1] ? bottom : top;
                out_next.u            = corner_reg[0] ? cur_reg.tr : cur_reg.tl;
                out_next.v            = corner_reg[1] ? cur_reg.tb : cur_reg.tt;
                out_next.missing_code = '0;
                out_next.last         = (corner_reg == gql_pkg::CORNER_BR);
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            corner_reg    <= gql_pkg::CORNER_TL;
            pen_x_reg     <= '0;
            pen_line_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            corner_reg    <= corner_next;
            pen_x_reg     <= pen_x_next;
            pen_line_reg  <= pen_line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= head;
        end
        out_reg <= out_next;
    end

    assign empty = !out_valid_reg;
    assign res   = out_reg;

    `GQL_ASSERT(a_corner_only_in_glyph, (corner_reg != gql_pkg::CORNER_TL) |-> (cur_valid_reg && (cur_reg.act == gql_pkg::ACT_GLYPH)))
    `GQL_ASSERT(a_last_on_br, (out_valid_reg && (out_reg.kind == gql_pkg::KIND_VERTEX) && out_reg.last) |-> (out_reg.corner == gql_pkg::CORNER_BR))

endmodule

// File: sv/glyph_quad_layout.sv
// Glyph quad layout engine. Requests come in through a push/full queue port:
// a load request (req_type 0) writes one glyph's metrics into a direct-mapped
// table at slot char_code mod GLYPH_SLOTS; a layout request (req_type 1)
// looks the character up under font_style; a hit advances the pen. A hit
// on a non-whitespace code yields four corner vertices (top-left, top-right,
// bottom-left, bottom-right; last marks the fourth), a miss yields one
// missing-glyph report, and a hit on newline, space or tab only moves the
// pen. Results leave through an empty/pop port, one per cycle at most, so a
// visible glyph holds the result side for its four vertices and a miss for
// its one report; whitespace passes the back end with no result. The front
// keeps accepting requests into its 8-entry queue while vertices drain. Up
// to 8 layout requests can wait between the request port and the back end,
// which works on one more while the result register holds another. A
// request passes the front stages, the queue, the back end's current entry
// and the result register before its first result shows. After reset the
// block holds full high while it clears the glyph tags. Configuration
// writes (scale, spacing, space and line advance, style) take effect at
// once and must only be issued with the block idle.
module glyph_quad_layout #(
    parameter int GLYPH_SLOTS = gql_pkg::GLYPH_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [gql_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gql_pkg::CFG_W-1:0]      cfg_wdata,
    // request side
    input  logic                           push,
    output logic                           full,
    input  logic                           req_type,
    input  logic [15:0]                    char_code,
    input  logic                           first_char,
    input  logic [5:0]                     load_style,
    input  logic signed [15:0]             offset_x,
    input  logic signed [15:0]             offset_y,
    input  logic signed [15:0]             box_width,
    input  logic signed [15:0]             box_height,
    input  logic [15:0]                    tex_left,
    input  logic [15:0]                    tex_right,
    input  logic [15:0]                    tex_top,
    input  logic [15:0]                    tex_bottom,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output logic                           out_kind,
    output logic [1:0]                     corner,
    output logic signed [15:0]             vert_x,
    output logic signed [15:0]             vert_y,
    output logic [15:0]                    vert_u,
    output logic [15:0]                    vert_v,
    output logic [15:0]                    missing_code,
    output logic                           last
);

    logic [15:0]       scale_q8_reg;
    logic signed [7:0] spacing_x_reg;
    logic [11:0]       space_advance_reg;
    logic [11:0]       line_advance_reg;
    logic [5:0]        font_style_reg;

    gql_pkg::cfg_t   cfg;
    gql_pkg::req_t   req;
    gql_pkg::entry_t enq_entry;
    gql_pkg::entry_t head;
    gql_pkg::res_t   res;
    logic            enq_valid;
    logic            head_valid;
    logic            deq;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_q8_reg      <= 16'd256;
            spacing_x_reg     <= '0;
            space_advance_reg <= 12'd5;
            line_advance_reg  <= 12'd16;
            font_style_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                gql_pkg::CFG_SCALE:      scale_q8_reg      <= cfg_wdata;
                gql_pkg::CFG_SPACING:    spacing_x_reg     <= cfg_wdata[7:0];
                gql_pkg::CFG_SPACE_ADV:  space_advance_reg <= cfg_wdata[11:0];
                gql_pkg::CFG_LINE_ADV:   line_advance_reg  <= cfg_wdata[11:0];
                gql_pkg::CFG_FONT_STYLE: font_style_reg    <= cfg_wdata[5:0];
                default:                 ;
            endcase
        end
    end

    assign cfg.scale     = scale_q8_reg;
    assign cfg.spacing   = spacing_x_reg;
    assign cfg.space_adv = space_advance_reg;
    assign cfg.line_adv  = line_advance_reg;
    assign cfg.style     = font_style_reg;

    assign req.req_type   = req_type;
    assign req.char_code  = char_code;
    assign req.first_char = first_char;
    assign req.load_style = load_style;
    assign req.offset_x   = offset_x;
    assign req.offset_y   = offset_y;
    assign req.box_width  = box_width;
    assign req.box_height = box_height;
    assign req.tex_left   = tex_left;
    assign req.tex_right  = tex_right;
    assign req.tex_top    = tex_top;
    assign req.tex_bottom = tex_bottom;

    // front: slot index, glyph table, classify and scale
    gql_front #(
        .GLYPH_SLOTS (GLYPH_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .req       (req),
        .deq       (deq),
        .enq_valid (enq_valid),
        .enq_entry (enq_entry)
    );

    // decouples lookups from vertex emission
    gql_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (enq_valid),
        .din      (enq_entry),
        .pop      (deq),
        .dout     (head),
        .nonempty (head_valid)
    );

    // back: pen tracking and per-corner vertex output
    gql_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .deq        (deq),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign out_kind     = res.kind;
    assign corner       = res.corner;
    assign vert_x       = res.x;
    assign vert_y       = res.y;
    assign vert_u       = res.u;
    assign vert_v       = res.v;
    assign missing_code = res.missing_code;
    assign last         = res.last;

endmodule

// File: verif/glyph_quad_layout_tb.sv
`timescale 1ns / 100ps

module glyph_quad_layout_tb;

    // settle time once no result is owed: the front stages may still hold
    // loads, and the 8-deep request queue may still hold whitespace
    localparam int SETTLE_CYCLES = 40;
    // cycles with no handshake at all before the run is declared hung;
    // covers the tag clearing pass after reset and the longest gaps
    localparam int HANG_LIMIT    = 4000;
    localparam int RESET_CYCLES  = 10;

    // register indexes past the last register; writes there do nothing
    localparam logic [gql_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [gql_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef enum logic [1:0] {
        STEP_REQ,   // one request on the push side
        STEP_CFG,   // one register write, issued only when the block is idle
        STEP_SYNC   // hold the sender until every owed result has drained
    } step_kind_t;

    typedef struct {
        step_kind_t                     kind;
        gql_pkg::req_t                  req;
        logic [gql_pkg::CFG_ADDR_W-1:0] addr;
        logic [gql_pkg::CFG_W-1:0]      data;
    } step_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // DUT inputs, all known from time zero
    logic                           cfg_we     = 1'b0;
    logic [gql_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
    logic [gql_pkg::CFG_W-1:0]      cfg_wdata  = '0;
    logic                           push       = 1'b0;
    logic                           pop        = 1'b0;
    logic                           req_type   = 1'b0;
    logic [15:0]                    char_code  = '0;
    logic                           first_char = 1'b0;
    logic [5:0]                     load_style = '0;
    logic signed [15:0]             offset_x   = '0;
    logic signed [15:0]             offset_y   = '0;
    logic signed [15:0]             box_width  = '0;
    logic signed [15:0]             box_height = '0;
    logic [15:0]                    tex_left   = '0;
    logic [15:0]                    tex_right  = '0;
    logic [15:0]                    tex_top    = '0;
    logic [15:0]                    tex_bottom = '0;

    // DUT outputs
    logic               full;
    logic               empty;
    logic               out_kind;
    logic [1:0]         corner;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic [15:0]        vert_u;
    logic [15:0]        vert_v;
    logic [15:0]        missing_code;
    logic               last;

    glyph_quad_layout uut (.*);

    // ------------------------------------------------------------------
    // Layout model: register copy, glyph table, pen
    // ------------------------------------------------------------------
    logic [15:0]       cfg_scale     = 16'd256;
    logic signed [7:0] cfg_spacing   = 8'sd0;
    logic [11:0]       cfg_space_adv = 12'd5;
    logic [11:0]       cfg_line_adv  = 12'd16;
    logic [5:0]        cfg_style     = 6'd0;

    logic               tag_ok    [gql_pkg::GLYPH_SLOTS_DEF] = '{default: 1'b0};
    logic [5:0]         tag_style [gql_pkg::GLYPH_SLOTS_DEF];
    logic [15:0]        tag_code  [gql_pkg::GLYPH_SLOTS_DEF];
    logic signed [15:0] g_ox      [gql_pkg::GLYPH_SLOTS_DEF];
    logic signed [15:0] g_oy      [gql_pkg::GLYPH_SLOTS_DEF];
    logic signed [15:0] g_w       [gql_pkg::GLYPH_SLOTS_DEF];
    logic signed [15:0] g_h       [gql_pkg::GLYPH_SLOTS_DEF];
    logic [15:0]        g_tl      [gql_pkg::GLYPH_SLOTS_DEF];
    logic [15:0]        g_tr      [gql_pkg::GLYPH_SLOTS_DEF];
    logic [15:0]        g_tt      [gql_pkg::GLYPH_SLOTS_DEF];
    logic [15:0]        g_tb      [gql_pkg::GLYPH_SLOTS_DEF];
    logic [15:0]        pen_x     = '0;
    logic [15:0]        pen_line  = '0;

    gql_pkg::res_t layout_out_q [$];   // vertices and missing reports still owed
    step_t         text_stream  [$];   // requests and register writes to send

    int fail_cnt   = 0;
    int idle_cnt   = 0;        // cycles with nothing owed and nothing sent
    int send_gap   = 0;
    int drain_gap  = 0;
    bit calm       = 1'b0;     // stretch with no idling on either side

    // Q8.8 scale, truncated toward zero, low 16 bits kept
    function automatic logic [15:0] scaled(input int v);
        longint p;
        p = longint'(v) * longint'(cfg_scale);
        p = p / 256;
        return p[15:0];
    endfunction

    function automatic void cfg_apply(input logic [gql_pkg::CFG_ADDR_W-1:0] idx,
                                      input logic [gql_pkg::CFG_W-1:0] d);
        case (idx)
            gql_pkg::CFG_SCALE:      cfg_scale     = d;
            gql_pkg::CFG_SPACING:    cfg_spacing   = d[7:0];
            gql_pkg::CFG_SPACE_ADV:  cfg_space_adv = d[11:0];
            gql_pkg::CFG_LINE_ADV:   cfg_line_adv  = d[11:0];
            gql_pkg::CFG_FONT_STYLE: cfg_style     = d[5:0];
            default:                 ;
        endcase
    endfunction

    // one accepted request: update table / pen, queue the owed results
    function automatic void layout_step(input gql_pkg::req_t r);
        int            slot;
        gql_pkg::res_t o;
        logic [15:0]   x_l, x_r, y_t, y_b;
        slot = r.char_code % gql_pkg::GLYPH_SLOTS_DEF;
        if (r.req_type == gql_pkg::REQ_LOAD)
        begin
            // tag, box and texture are always written together
            tag_ok[slot]    = 1'b1;
            tag_style[slot] = r.load_style;
            tag_code[slot]  = r.char_code;
            g_ox[slot] = r.offset_x;
            g_oy[slot] = r.offset_y;
            g_w[slot]  = r.box_width;
            g_h[slot]  = r.box_height;
            g_tl[slot] = r.tex_left;
            g_tr[slot] = r.tex_right;
            g_tt[slot] = r.tex_top;
            g_tb[slot] = r.tex_bottom;
            return;
        end
        if (r.first_char)
        begin
            pen_x    = '0;
            pen_line = '0;
        end
        // whitespace has to hit too; a miss moves the pen only through first_char
        if (!(tag_ok[slot] && tag_style[slot] == cfg_style &&
              tag_code[slot] == r.char_code))
        begin
            o              = '0;
            o.kind         = gql_pkg::KIND_MISSING;
            o.missing_code = r.char_code;
            o.last         = 1'b1;
            layout_out_q.insert(layout_out_q.size(), o);
            return;
        end
        if (r.char_code == gql_pkg::CODE_NL)
        begin
            pen_line = pen_line + {4'b0, cfg_line_adv};
            pen_x    = '0;
        end
        else if (r.char_code == gql_pkg::CODE_SP)
        begin
            pen_x = pen_x + {4'b0, cfg_space_adv};
        end
        else if (r.char_code == gql_pkg::CODE_TAB)
        begin
            pen_x = pen_x + ({4'b0, cfg_space_adv} << 2);
        end
        else
        begin
            x_l = pen_x + scaled(int'(g_ox[slot]));
            x_r = x_l + scaled(int'(g_w[slot]));
            y_t = pen_line + scaled(int'(g_oy[slot]));
            y_b = y_t + scaled(int'(g_h[slot]));
            // corner bit 0 picks right, bit 1 picks bottom
            for (int c = 0; c < 4; c++)
            begin
                o        = '0;
                o.kind   = gql_pkg::KIND_VERTEX;
                o.corner = 2'(c);
                o.x      = c[0] ? x_r : x_l;
                o.y      = c[1] ? y_b : y_t;
                o.u      = c[0] ? g_tr[slot] : g_tl[slot];
                o.v      = c[1] ? g_tb[slot] : g_tt[slot];
                o.last   = (2'(c) == gql_pkg::CORNER_BR);
                layout_out_q.insert(layout_out_q.size(), o);
            end
            pen_x = pen_x + scaled(int'(g_w[slot]) + int'(cfg_spacing));
        end
    endfunction

    // mostly short gaps, some long ones, and calm stretches with none
    function automatic int pick_gap();
        int unsigned r;
        if ($urandom_range(0, 49) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void add_load(input logic [15:0] code, input logic [5:0] sty,
                                     input logic [15:0] ox, input logic [15:0] oy,
                                     input logic [15:0] w, input logic [15:0] h,
                                     input logic [15:0] tl, input logic [15:0] tr,
                                     input logic [15:0] tt, input logic [15:0] tb);
        step_t s;
        s.kind = STEP_REQ;
        s.addr = '0;
        s.data = '0;
        s.req  = '{req_type: gql_pkg::REQ_LOAD, char_code: code,
                   first_char: 1'($urandom_range(0, 1)), load_style: sty,
                   offset_x: ox, offset_y: oy, box_width: w, box_height: h,
                   tex_left: tl, tex_right: tr, tex_top: tt, tex_bottom: tb};
        text_stream.insert(text_stream.size(), s);
    endfunction

    // layout request; the load-only fields carry noise
    function automatic void add_char(input logic [15:0] code, input logic first);
        step_t s;
        s.kind = STEP_REQ;
        s.addr = '0;
        s.data = '0;
        s.req  = '{req_type: gql_pkg::REQ_LAYOUT, char_code: code, first_char: first,
                   load_style: 6'($urandom()),
                   offset_x: 16'($urandom()), offset_y: 16'($urandom()),
                   box_width: 16'($urandom()), box_height: 16'($urandom()),
                   tex_left: 16'($urandom()), tex_right: 16'($urandom()),
                   tex_top: 16'($urandom()), tex_bottom: 16'($urandom())};
        text_stream.insert(text_stream.size(), s);
    endfunction

    function automatic void add_cfg(input logic [gql_pkg::CFG_ADDR_W-1:0] idx,
                                    input logic [gql_pkg::CFG_W-1:0] d);
        step_t s;
        s.kind = STEP_CFG;
        s.req  = '0;
        s.addr = idx;
        s.data = d;
        text_stream.insert(text_stream.size(), s);
    endfunction

    function automatic void add_sync();
        step_t s;
        s.kind = STEP_SYNC;
        s.req  = '0;
        s.addr = '0;
        s.data = '0;
        text_stream.insert(text_stream.size(), s);
    endfunction

    // glyph metric: mostly small, some full range, a few extremes
    function automatic logic [15:0] rand_metric();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 16'($urandom_range(0, 96)) - 16'd48;
        if (r < 92)
            return 16'($urandom());
        return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
    endfunction

    // codes: printable ASCII, codes that fight over a few slots,
    // whitespace, and anything at all
    function automatic logic [15:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 16'($urandom_range(33, 126));
        if (r < 70)
            return 16'($urandom_range(0, 3) * 256 + $urandom_range(64, 71));
        if (r < 82)
        begin
            case ($urandom_range(0, 2))
                0:       return gql_pkg::CODE_NL;
                1:       return gql_pkg::CODE_SP;
                default: return gql_pkg::CODE_TAB;
            endcase
        end
        return 16'($urandom());
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            3:       return 16'd128;
            4:       return 16'd384;
            default: return 16'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: sends queued requests, issues register writes when idle,
    // and runs the model on every accepted request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive
        step_t s;
        logic  nxt_push;
        logic  nxt_we;
        bit    settled;
        if (rst_n)
        begin
            nxt_push = push;
            nxt_we   = 1'b0;
            if (push && !full)
            begin
                layout_step('{req_type, char_code, first_char, load_style,
                              offset_x, offset_y, box_width, box_height,
                              tex_left, tex_right, tex_top, tex_bottom});
                nxt_push = 1'b0;
                send_gap = pick_gap();
            end
            // the block takes the write at this edge
            if (cfg_we)
                cfg_apply(cfg_addr, cfg_wdata);

            if ((push && !full) || layout_out_q.size() != 0)
                idle_cnt = 0;
            else if (idle_cnt < SETTLE_CYCLES)
                idle_cnt++;
            settled = (idle_cnt >= SETTLE_CYCLES) && !full && !push;

            if (!nxt_push)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                end
                else if (text_stream.size() != 0)
                begin
                    s = text_stream[0];
                    case (s.kind)
                        STEP_REQ:
                        begin
                            req_type   <= s.req.req_type;
                            char_code  <= s.req.char_code;
                            first_char <= s.req.first_char;
                            load_style <= s.req.load_style;
                            offset_x   <= s.req.offset_x;
                            offset_y   <= s.req.offset_y;
                            box_width  <= s.req.box_width;
                            box_height <= s.req.box_height;
                            tex_left   <= s.req.tex_left;
                            tex_right  <= s.req.tex_right;
                            tex_top    <= s.req.tex_top;
                            tex_bottom <= s.req.tex_bottom;
                            nxt_push   = 1'b1;
                            void'(text_stream.pop_front());
                        end
                        STEP_CFG:
                        begin
                            if (settled)
                            begin
                                cfg_addr  <= s.addr;
                                cfg_wdata <= s.data;
                                nxt_we    = 1'b1;
                                void'(text_stream.pop_front());
                            end
                        end
                        default:
                        begin
                            if (settled)
                                void'(text_stream.pop_front());
                        end
                    endcase
                end
            end
            push   <= nxt_push;
            cfg_we <= nxt_we;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pops results with random stalls, checks each field
    // ------------------------------------------------------------------
    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin : collect
        gql_pkg::res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (layout_out_q.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: unexpected result: expected none, got kind %0d corner %0d",
                             $time, out_kind, corner);
                    $display("%0t:   x %h y %h code %h", $time, vert_x, vert_y,
                             missing_code);
                end
                else
                begin
                    want = layout_out_q.pop_front();
                    check_field("out_kind", 16'(want.kind), 16'(out_kind));
                    check_field("corner", 16'(want.corner), 16'(corner));
                    check_field("vert_x", want.x, vert_x);
                    check_field("vert_y", want.y, vert_y);
                    check_field("vert_u", want.u, vert_u);
                    check_field("vert_v", want.v, vert_v);
                    check_field("missing_code", want.missing_code, missing_code);
                    check_field("last", 16'(want.last), 16'(last));
                end
                drain_gap = pick_gap();
            end
            else if (drain_gap != 0)
            begin
                drain_gap--;
            end
            pop <= (drain_gap == 0);
        end
    end

    // hang detection: no request, result or register write for too long
    int hang_cnt = 0;
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_we)
            hang_cnt <= 0;
        else
            hang_cnt <= hang_cnt + 1;
        if (hang_cnt >= HANG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [15:0] known [$];
        logic [15:0] code;
        logic [5:0]  plan_style;
        int unsigned r;

        // directed: nothing loaded yet, so a glyph and a space both miss
        add_char(16'd65, 1'b1);
        add_char(gql_pkg::CODE_SP, 1'b0);
        add_load(16'd65, 6'd0, 16'd2, -16'sd12, 16'd8, 16'd12,
                 16'h3800, 16'h3C00, 16'h0000, 16'h3400);
        add_load(gql_pkg::CODE_SP, 6'd0, rand_metric(), rand_metric(), rand_metric(),
                 rand_metric(), 16'h1111, 16'h2222, 16'h3333, 16'h4444);
        add_load(gql_pkg::CODE_NL, 6'd0, rand_metric(), rand_metric(), rand_metric(),
                 rand_metric(), 16'h5555, 16'h6666, 16'h7777, 16'h8888);
        add_load(gql_pkg::CODE_TAB, 6'd0, rand_metric(), rand_metric(), rand_metric(),
                 rand_metric(), 16'h9999, 16'hAAAA, 16'hBBBB, 16'hCCCC);
        // a line of text with every pen move
        add_char(16'd65, 1'b1);
        add_char(gql_pkg::CODE_SP, 1'b0);
        add_char(16'd65, 1'b0);
        add_char(gql_pkg::CODE_TAB, 1'b0);
        add_char(gql_pkg::CODE_NL, 1'b0);
        add_char(16'd65, 1'b0);
        // top code, top style, extreme metrics; style 0 lookups miss it
        add_load(16'hFFFF, 6'd63, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        add_char(16'hFFFF, 1'b0);
        // same slot as 'A': evicts it, then 'A' misses twice in a row
        add_load(16'h0141, 6'd0, rand_metric(), rand_metric(), rand_metric(),
                 rand_metric(), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()));
        add_char(16'd65, 1'b0);
        add_char(16'd65, 1'b0);
        add_char(16'h0141, 1'b0);
        add_load(16'h0000, 6'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        add_char(16'h0000, 1'b1);

        // register extremes, plus writes to unused indexes
        add_cfg(gql_pkg::CFG_SCALE, 16'hFFFF);
        add_cfg(gql_pkg::CFG_SPACING, 16'hFF80);
        add_cfg(gql_pkg::CFG_SPACE_ADV, 16'h0FFF);
        add_cfg(gql_pkg::CFG_LINE_ADV, 16'h0FFF);
        add_cfg(gql_pkg::CFG_FONT_STYLE, 16'h003F);
        add_cfg(CFG_UNUSED_LO, 16'hFFFF);
        add_cfg(CFG_UNUSED_HI, 16'h0000);
        add_load(gql_pkg::CODE_SP, 6'd63, rand_metric(), rand_metric(), rand_metric(),
                 rand_metric(), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()));
        add_char(16'hFFFF, 1'b1);
        add_char(gql_pkg::CODE_SP, 1'b0);
        add_char(16'hFFFF, 1'b0);
        add_char(gql_pkg::CODE_NL, 1'b0);    // loaded under style 0 only
        add_cfg(gql_pkg::CFG_SCALE, 16'h0000);
        add_cfg(gql_pkg::CFG_SPACING, 16'h007F);
        add_char(16'hFFFF, 1'b0);

        // random phases: new register set, then mostly loads followed by
        // layout of codes already loaded, with some noise
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 0)
                plan_style = 6'd0;
            else if (ph == 4)
                plan_style = 6'd63;
            else
                plan_style = 6'($urandom_range(0, 3));
            add_cfg(gql_pkg::CFG_SCALE, (ph == 0) ? 16'd256 : pick_scale());
            add_cfg(gql_pkg::CFG_SPACING, 16'($urandom_range(0, 255)));
            add_cfg(gql_pkg::CFG_SPACE_ADV, 16'($urandom_range(0, 4095)));
            add_cfg(gql_pkg::CFG_LINE_ADV, 16'($urandom_range(0, 4095)));
            add_cfg(gql_pkg::CFG_FONT_STYLE, 16'(plan_style));
            for (int n = 0; n < 35; n++)
            begin
                // one pause with the sender held until everything drained
                if (ph == 2 && n == 17)
                    add_sync();
                r = $urandom_range(0, 99);
                if (r < 25)
                begin
                    code = pick_code();
                    add_load(code,
                             ($urandom_range(0, 9) < 8) ? plan_style : 6'($urandom()),
                             rand_metric(), rand_metric(), rand_metric(), rand_metric(),
                             16'($urandom()), 16'($urandom()),
                             16'($urandom()), 16'($urandom()));
                    known.insert(known.size(), code);
                end
                else if (r < 85 && known.size() != 0)
                begin
                    add_char(known[$urandom_range(0, known.size() - 1)],
                             $urandom_range(0, 9) == 0);
                end
                else
                begin
                    add_char(pick_code(), $urandom_range(0, 9) == 0);
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // all sent, nothing owed, then let stragglers show up
        while (text_stream.size() != 0 || push || layout_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/gql_pkg.sv
sv/gql_front.sv
sv/gql_fifo.sv
sv/gql_back.sv
sv/glyph_quad_layout.sv
verif/glyph_quad_layout_tb.sv
